// ----- hdl/periodic_voxel_sphere_paint_core_assert.svh -----
// Assertion macros for the periodic voxel sphere paint core.
// Used by the top level; expects clk and rst in the including scope.
`ifndef PERIODIC_VOXEL_SPHERE_PAINT_CORE_ASSERT_SVH
`define PERIODIC_VOXEL_SPHERE_PAINT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PVSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvsp assertion failed");

// Next-cycle implication, disabled during reset.
`define PVSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pvsp assertion failed");

`endif

// ----- hdl/pvsp_pkg.sv -----
// Package for the periodic voxel sphere paint core: types, codes, constants.
// No dependencies.
package pvsp_pkg;

  localparam int MAX_DIM    = 32;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_DIM);
  localparam int ADDR_BITS  = 3 * IDX_BITS;
  localparam int DEPTH      = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int DIM_BITS   = 6;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NOP  = 2'd3;

  localparam logic [2:0] CFG_CELL_A = 3'd0;
  localparam logic [2:0] CFG_CELL_B = 3'd1;
  localparam logic [2:0] CFG_CELL_C = 3'd2;
  localparam logic [2:0] CFG_INV_A  = 3'd3;
  localparam logic [2:0] CFG_INV_B  = 3'd4;
  localparam logic [2:0] CFG_INV_C  = 3'd5;
  localparam logic [2:0] CFG_GRID   = 3'd6;

  localparam logic [17:0] GRID_RESET = 18'd133152;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [15:0]        radius;
    logic signed [15:0] paint_value;
    logic [4:0]         voxel_i;
    logic [4:0]         voxel_j;
    logic [4:0]         voxel_k;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic [15:0]        voxels_hit;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_CF, ST_VOX, ST_RD_ADDR, ST_RD_DATA, ST_FINISH
  } state_t;

  // One signed 16-bit part of a packed 48-bit row: x, y, z from the top.
  function automatic logic [15:0] part16(input logic [47:0] row, input logic [1:0] idx);
    logic [15:0] p;
    unique case (idx)
      2'd0:    p = row[47:32];
      2'd1:    p = row[31:16];
      default: p = row[15:0];
    endcase
    return p;
  endfunction

  // Clamp a raw 6-bit dimension field to 1..MAX_DIM.
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [5:0] f);
    logic [DIM_BITS-1:0] n;
    if (f == 6'd0) n = DIM_BITS'(1);
    else if (32'(f) > MAX_DIM) n = DIM_BITS'(MAX_DIM);
    else n = DIM_BITS'(f);
    return n;
  endfunction

endpackage

// ----- hdl/pvsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/periodic_voxel_sphere_paint_core.sv -----
// Top level of the periodic voxel sphere paint core.
// Depends on pvsp_pkg, pvsp_ram and periodic_voxel_sphere_paint_core_assert.svh.
//
// Usage:
// A command word on cmd is taken at a clock edge with start high and busy low.
// Set and add commands paint a sphere into the voxel store of a periodic
// cell; a read command returns one stored voxel. Each command produces one
// result word on result, marked by done for exactly one cycle; the receiver
// must take it then, it cannot stall the block.
// Configuration is written through cfg_we, cfg_index and cfg_data, one
// register per edge; the user must write only while busy is low, which
// the block itself does not enforce. A read passes through an address
// and a data state to its result. A set or add command divides out the
// voxel spacing per axis, then forms the fractional center and radius
// squared, then walks every voxel of the grid, where one shared
// multiply-accumulate unit does nine products and three squares per
// voxel, and then gives the result.
// After reset a clearing pass zeroes all 32768 entries of the store, one
// entry per cycle, with busy high; configuration writes are taken meanwhile.
module periodic_voxel_sphere_paint_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pvsp_pkg::in_word_t  cmd,
  output logic                done,
  output pvsp_pkg::out_word_t result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import pvsp_pkg::*;

  // Configuration registers.
  logic [47:0] cell_row_a, cell_row_b, cell_row_c;
  logic [47:0] inverse_row_a, inverse_row_b, inverse_row_c;
  logic [17:0] grid_dims;

  // Sequencer and datapath state.
  state_t state, state_next;
  in_word_t cur;
  logic [ADDR_BITS-1:0] clr_addr;
  logic [1:0]  ax;
  logic [3:0]  dcnt;
  logic [4:0]  drem;
  logic [15:0] dq;
  logic [15:0] q0 [3];
  logic [5:0]  r0 [3];
  logic [16:0] qinc [3];
  logic [5:0]  rinc [3];
  logic [16:0] vfq [3];
  logic [5:0]  vfr [3];
  logic [15:0] cf [3];
  logic [31:0] r2;
  logic signed [33:0] acc;
  logic [34:0] dist_sum;
  logic [3:0]  step;
  logic [IDX_BITS-1:0] vi, vj, vk;
  logic [15:0] hits;

  // Combinational signals.
  logic [DIM_BITS-1:0] n [3];
  logic [DIM_BITS-1:0] n_ax;
  logic [1:0]  sub, col;
  logic [16:0] vfq_sel;
  logic [15:0] cf_sel, ctr_sel, d_sel;
  logic [47:0] inv_sel, cell_sel;
  logic [15:0] inv_part, cell_part;
  logic signed [17:0] op_a, op_b;
  logic signed [35:0] prod;
  logic [5:0]  rem_s;
  logic        div_ge;
  logic [5:0]  div_rem;
  logic [15:0] div_q;
  logic [6:0]  two_r;
  logic        last_i, last_j, last_k, hit;
  logic signed [16:0] sum_val;
  logic [15:0] add_val;
  logic        ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;

  assign busy = (state != ST_IDLE);
  assign sub  = step[1:0];
  assign col  = step[3:2];

  // Clamped grid dimensions.
  assign n[0] = clamp_dim(grid_dims[17:12]);
  assign n[1] = clamp_dim(grid_dims[11:6]);
  assign n[2] = clamp_dim(grid_dims[5:0]);

  // Per-axis selection for the divider and the multiply-accumulate unit.
  always_comb begin
    unique case (ax)
      2'd0:    n_ax = n[0];
      2'd1:    n_ax = n[1];
      default: n_ax = n[2];
    endcase
    unique case (sub)
      2'd0: begin
        vfq_sel = vfq[0]; cf_sel = cf[0]; ctr_sel = cur.center_x;
        inv_sel = inverse_row_a; cell_sel = cell_row_a;
      end
      2'd1: begin
        vfq_sel = vfq[1]; cf_sel = cf[1]; ctr_sel = cur.center_y;
        inv_sel = inverse_row_b; cell_sel = cell_row_b;
      end
      default: begin
        vfq_sel = vfq[2]; cf_sel = cf[2]; ctr_sel = cur.center_z;
        inv_sel = inverse_row_c; cell_sel = cell_row_c;
      end
    endcase
  end

  // Minimum-image fractional displacement wraps in 16 bits.
  assign d_sel = vfq_sel[15:0] - cf_sel;

  // Matrix parts for the current column.
  assign inv_part  = part16(inv_sel, col);
  assign cell_part = part16(cell_sel, col);

  // Shared multiplier operand selection.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == ST_CF) begin
      if (step == 4'd12) begin
        op_a = signed'({2'b00, cur.radius});
        op_b = signed'({2'b00, cur.radius});
      end else begin
        op_a = signed'({{2{ctr_sel[15]}}, ctr_sel});
        op_b = signed'({{2{inv_part[15]}}, inv_part});
      end
    end else if (state == ST_VOX) begin
      if (sub == 2'd3) begin
        op_a = acc[33:16];
        op_b = acc[33:16];
      end else begin
        op_a = signed'({{2{d_sel[15]}}, d_sel});
        op_b = signed'({{2{cell_part[15]}}, cell_part});
      end
    end
  end

  assign prod = op_a * op_b;

  // One restoring-division step of 32768 / n for the current axis.
  always_comb begin
    rem_s   = {drem, (dcnt == 4'd0)};
    div_ge  = (rem_s >= n_ax);
    div_rem = div_ge ? (rem_s - n_ax) : rem_s;
    div_q   = {dq[14:0], div_ge};
    two_r   = {div_rem, 1'b0};
  end

  // Voxel decision and saturating add.
  assign hit     = (dist_sum <= {3'b000, r2});
  assign sum_val = 17'(signed'(ram_rdata)) + 17'(cur.paint_value);
  always_comb begin
    if (sum_val > 17'sd32767) add_val = 16'h7FFF;
    else if (sum_val < -17'sd32768) add_val = 16'h8000;
    else add_val = sum_val[15:0];
  end
  assign last_i = ({1'b0, vi} == n[0] - 1'b1);
  assign last_j = ({1'b0, vj} == n[1] - 1'b1);
  assign last_k = ({1'b0, vk} == n[2] - 1'b1);

  // Voxel store port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {vi, vj, vk};
    ram_wdata = (cur.req_type == REQ_SET) ? cur.paint_value : add_val;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_VOX && step == 4'd12 && hit) begin
      ram_we = 1'b1;
    end
    ram_raddr = (state == ST_VOX) ? {vi, vj, vk} : {cur.voxel_i, cur.voxel_j, cur.voxel_k};
  end

  pvsp_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_row_a <= '0; cell_row_b <= '0; cell_row_c <= '0;
      inverse_row_a <= '0; inverse_row_b <= '0; inverse_row_c <= '0;
      grid_dims <= GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_A: cell_row_a    <= cfg_data;
        CFG_CELL_B: cell_row_b    <= cfg_data;
        CFG_CELL_C: cell_row_c    <= cfg_data;
        CFG_INV_A:  inverse_row_a <= cfg_data;
        CFG_INV_B:  inverse_row_b <= cfg_data;
        CFG_INV_C:  inverse_row_c <= cfg_data;
        CFG_GRID:   grid_dims     <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (cmd.req_type)
            REQ_READ: state_next = ST_RD_ADDR;
            REQ_NOP:  state_next = ST_FINISH;
            default:  state_next = ST_DIV;
          endcase
        end
      end
      ST_DIV:     if (ax == 2'd2 && dcnt == 4'd15) state_next = ST_CF;
      ST_CF:      if (step == 4'd12) state_next = ST_VOX;
      ST_VOX:     if (step == 4'd12 && last_i && last_j && last_k) state_next = ST_FINISH;
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_IDLE;
      ST_FINISH:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Result strobe and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      clr_addr <= '0;
    end else begin
      done <= (state == ST_RD_DATA) || (state == ST_FINISH);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Datapath: command capture, divider, multiply-accumulate and voxel walk.
  always_ff @(posedge clk) begin
    if (state == ST_RD_DATA) begin
      result.voxels_hit <= '0;
      if ({1'b0, cur.voxel_i} < n[0] && {1'b0, cur.voxel_j} < n[1] &&
          {1'b0, cur.voxel_k} < n[2]) begin
        result.read_value <= ram_rdata;
      end else begin
        result.read_value <= '0;
      end
    end else if (state == ST_FINISH) begin
      result.read_value <= '0;
      result.voxels_hit <= hits;
    end

    unique case (state)
      ST_IDLE: begin
        cur      <= cmd;
        ax       <= '0;
        dcnt     <= '0;
        drem     <= '0;
        dq       <= '0;
        step     <= '0;
        acc      <= '0;
        dist_sum <= '0;
        hits     <= '0;
        vi       <= '0;
        vj       <= '0;
        vk       <= '0;
      end
      ST_DIV: begin
        drem <= div_rem[4:0];
        dq   <= div_q;
        dcnt <= dcnt + 1'b1;
        if (dcnt == 4'd15) begin
          drem <= '0;
          dq   <= '0;
          ax   <= ax + 1'b1;
          for (int a = 0; a < 3; a++) begin
            if (ax == 2'(a)) begin
              q0[a]  <= div_q;
              r0[a]  <= div_rem;
              vfq[a] <= {1'b0, div_q};
              vfr[a] <= div_rem;
              if (two_r >= {1'b0, n_ax}) begin
                qinc[a] <= {div_q, 1'b1};
                rinc[a] <= 6'(two_r - {1'b0, n_ax});
              end else begin
                qinc[a] <= {div_q, 1'b0};
                rinc[a] <= two_r[5:0];
              end
            end
          end
        end
      end
      ST_CF: begin
        step <= (step == 4'd12) ? 4'd0 : step + 1'b1;
        if (step == 4'd12) begin
          r2 <= prod[31:0];
        end else if (sub == 2'd3) begin
          acc <= '0;
          for (int a = 0; a < 3; a++) begin
            if (col == 2'(a)) cf[a] <= acc[19:4];
          end
        end else begin
          acc <= acc + prod[33:0];
        end
      end
      ST_VOX: begin
        step <= (step == 4'd12) ? 4'd0 : step + 1'b1;
        if (step == 4'd12) begin
          dist_sum <= '0;
          if (hit && hits != 16'hFFFF) hits <= hits + 1'b1;
          // Walk k fastest, then j, then i; fractions advance by 1/n.
          if (last_k) begin
            vk <= '0; vfq[2] <= {1'b0, q0[2]}; vfr[2] <= r0[2];
          end else begin
            vk <= vk + 1'b1;
            if (7'(vfr[2]) + 7'(rinc[2]) >= 7'(n[2])) begin
              vfr[2] <= 6'(7'(vfr[2]) + 7'(rinc[2]) - 7'(n[2]));
              vfq[2] <= vfq[2] + qinc[2] + 1'b1;
            end else begin
              vfr[2] <= vfr[2] + rinc[2];
              vfq[2] <= vfq[2] + qinc[2];
            end
          end
          if (last_k) begin
            if (last_j) begin
              vj <= '0; vfq[1] <= {1'b0, q0[1]}; vfr[1] <= r0[1];
            end else begin
              vj <= vj + 1'b1;
              if (7'(vfr[1]) + 7'(rinc[1]) >= 7'(n[1])) begin
                vfr[1] <= 6'(7'(vfr[1]) + 7'(rinc[1]) - 7'(n[1]));
                vfq[1] <= vfq[1] + qinc[1] + 1'b1;
              end else begin
                vfr[1] <= vfr[1] + rinc[1];
                vfq[1] <= vfq[1] + qinc[1];
              end
            end
          end
          if (last_k && last_j) begin
            if (last_i) begin
              vi <= '0; vfq[0] <= {1'b0, q0[0]}; vfr[0] <= r0[0];
            end else begin
              vi <= vi + 1'b1;
              if (7'(vfr[0]) + 7'(rinc[0]) >= 7'(n[0])) begin
                vfr[0] <= 6'(7'(vfr[0]) + 7'(rinc[0]) - 7'(n[0]));
                vfq[0] <= vfq[0] + qinc[0] + 1'b1;
              end else begin
                vfr[0] <= vfr[0] + rinc[0];
                vfq[0] <= vfq[0] + qinc[0];
              end
            end
          end
        end else if (sub == 2'd3) begin
          acc      <= '0;
          dist_sum <= dist_sum + prod[34:0];
        end else begin
          acc <= acc + prod[33:0];
        end
      end
      default: ;
    endcase
  end

  // Assertions.
  `include "periodic_voxel_sphere_paint_core_assert.svh"

  `PVSP_ASSERT_IMP(a_idle_no_write, state == ST_IDLE, !ram_we)
  `PVSP_ASSERT_NEXT(a_done_single, done, !done)
  `PVSP_ASSERT_IMP(a_vox_in_grid, state == ST_VOX, last_i || ({1'b0, vi} < n[0]))
  `PVSP_ASSERT_IMP(a_step_range, (state == ST_VOX) || (state == ST_CF), step <= 4'd12)

endmodule

// ----- bench/tb_periodic_voxel_sphere_paint_core.sv -----
// Testbench for periodic_voxel_sphere_paint_core: directed and random set, add,
// read and no-op words under several cell, inverse and grid settings.
// Depends on pvsp_pkg and the core RTL; a scoreboard class predicts every result.
module tb_periodic_voxel_sphere_paint_core;
  import pvsp_pkg::*;

  // Predicts each result word from the accepted command words and checks it.
  class voxel_paint_scoreboard;
    logic [47:0] cell_rows[3];
    logic [47:0] inv_rows[3];
    logic [17:0] grid;
    logic [15:0] voxels[DEPTH];
    out_word_t   pending_results[$];
    int          errors;

    function void reset_state();
      for (int a = 0; a < 3; a++) begin
        cell_rows[a] = '0;
        inv_rows[a]  = '0;
      end
      grid = GRID_RESET;
      foreach (voxels[e]) voxels[e] = '0;
      pending_results.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        CFG_CELL_A: cell_rows[0] = data;
        CFG_CELL_B: cell_rows[1] = data;
        CFG_CELL_C: cell_rows[2] = data;
        CFG_INV_A:  inv_rows[0]  = data;
        CFG_INV_B:  inv_rows[1]  = data;
        CFG_INV_C:  inv_rows[2]  = data;
        CFG_GRID:   grid         = data[17:0];
        default: ;
      endcase
    endfunction

    // Signed component col (x, y, z from the top) of a packed row.
    function longint row_part(logic [47:0] row, int col);
      logic signed [15:0] p;
      p = row[47 - 16 * col -: 16];
      return longint'(p);
    endfunction

    function int axis_count(int a);
      int f;
      f = (grid >> (12 - 6 * a)) & 63;
      if (f < 1) f = 1;
      if (f > MAX_DIM) f = MAX_DIM;
      return f;
    endfunction

    function logic [15:0] sat16(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    // Applies one command word to the voxel copy and returns its result.
    function out_word_t paint_or_read(in_word_t w);
      out_word_t          res;
      int                 n[3];
      int                 v[3];
      longint             s, m, dist2, r2, pv;
      logic [15:0]        frac_c[3];
      logic signed [15:0] d[3];
      logic [31:0]        vf;
      int                 hits, addr;
      res = '0;
      for (int a = 0; a < 3; a++) n[a] = axis_count(a);
      if (w.req_type == REQ_READ) begin
        if (w.voxel_i < n[0] && w.voxel_j < n[1] && w.voxel_k < n[2])
          res.read_value = voxels[{w.voxel_i, w.voxel_j, w.voxel_k}];
        return res;
      end
      if (w.req_type == REQ_NOP) return res;
      r2 = longint'(w.radius) * longint'(w.radius);
      pv = longint'(w.paint_value);
      // Fractional center: Q12.20 sum down to Q0.16, wrapping.
      for (int col = 0; col < 3; col++) begin
        s = longint'(w.center_x) * row_part(inv_rows[0], col)
          + longint'(w.center_y) * row_part(inv_rows[1], col)
          + longint'(w.center_z) * row_part(inv_rows[2], col);
        frac_c[col] = s[19:4];
      end
      hits = 0;
      for (int i = 0; i < n[0]; i++)
        for (int j = 0; j < n[1]; j++)
          for (int k = 0; k < n[2]; k++) begin
            v[0] = i; v[1] = j; v[2] = k;
            for (int a = 0; a < 3; a++) begin
              vf = ((2 * v[a] + 1) << 16) / (2 * n[a]);
              d[a] = vf[15:0] - frac_c[a];
            end
            dist2 = 0;
            for (int col = 0; col < 3; col++) begin
              s = longint'(d[0]) * row_part(cell_rows[0], col)
                + longint'(d[1]) * row_part(cell_rows[1], col)
                + longint'(d[2]) * row_part(cell_rows[2], col);
              m = s >>> 16;
              dist2 += m * m;
            end
            if (dist2 <= r2) begin
              addr = (i * MAX_DIM + j) * MAX_DIM + k;
              if (w.req_type == REQ_SET) voxels[addr] = pv[15:0];
              else voxels[addr] = sat16(longint'($signed(voxels[addr])) + pv);
              if (hits < 65535) hits++;
            end
          end
      res.voxels_hit = hits[15:0];
      return res;
    endfunction

    function void note_command(in_word_t w);
      pending_results = {pending_results, paint_or_read(w)};
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value expected %h actual %h", want.read_value, got.read_value);
        errors++;
      end
      if (got.voxels_hit !== want.voxels_hit) begin
        $error("voxels_hit expected %0d actual %0d", want.voxels_hit, got.voxels_hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    cmd;
  logic        done;
  out_word_t   result;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  voxel_paint_scoreboard sb;
  int  dim_now[3];
  bit  no_gaps;
  int  scale;

  periodic_voxel_sphere_paint_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked at its edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Generous bound: clearing pass plus every command at its slowest grid.
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Presents one word and holds start until the block takes it.
  task automatic send_word(in_word_t w);
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    sb.note_command(w);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (!no_gaps && $urandom_range(0, 99) < 9) pause($urandom_range(1, 6));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Loads a whole setting: cell rows, inverse rows and grid fields.
  task automatic load_setting(logic [47:0] c0, logic [47:0] c1, logic [47:0] c2,
                              logic [47:0] i0, logic [47:0] i1, logic [47:0] i2,
                              logic [5:0] g0, logic [5:0] g1, logic [5:0] g2);
    write_reg(CFG_CELL_A, c0);
    write_reg(CFG_CELL_B, c1);
    write_reg(CFG_CELL_C, c2);
    write_reg(CFG_INV_A, i0);
    write_reg(CFG_INV_B, i1);
    write_reg(CFG_INV_C, i2);
    write_reg(CFG_GRID, {30'd0, g0, g1, g2});
    cfg_we <= 1'b0;
    for (int a = 0; a < 3; a++) dim_now[a] = sb.axis_count(a);
  endtask

  // Orthogonal cell of edge len (Q8.8) and its inverse (Q4.12).
  task automatic load_cubic(int len, logic [5:0] g0, logic [5:0] g1, logic [5:0] g2);
    logic [15:0] e, r;
    e = 16'(len);
    r = 16'((4096 * 256) / len);
    scale = len;
    load_setting({e, 16'd0, 16'd0}, {16'd0, e, 16'd0}, {16'd0, 16'd0, e},
                 {r, 16'd0, 16'd0}, {16'd0, r, 16'd0}, {16'd0, 16'd0, r},
                 g0, g1, g2);
  endtask

  function automatic in_word_t make_word(logic [1:0] req, int cx, int cy, int cz,
                                         int rad, int val, int vi, int vj, int vk);
    in_word_t w;
    w.req_type    = req;
    w.center_x    = cx[15:0];
    w.center_y    = cy[15:0];
    w.center_z    = cz[15:0];
    w.radius      = rad[15:0];
    w.paint_value = val[15:0];
    w.voxel_i     = vi[4:0];
    w.voxel_j     = vj[4:0];
    w.voxel_k     = vk[4:0];
    return w;
  endfunction

  // Random word: mostly spheres near the cell and reads inside the grid.
  function automatic in_word_t random_word();
    in_word_t     w;
    logic [127:0] raw;
    int           pick;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 30) w.req_type = REQ_SET;
    else if (pick < 60) w.req_type = REQ_ADD;
    else if (pick < 95) w.req_type = REQ_READ;
    else w.req_type = REQ_NOP;
    if ($urandom_range(0, 3) != 0) begin
      w.center_x = 16'($signed($urandom_range(0, 4 * scale)) - 2 * scale);
      w.center_y = 16'($signed($urandom_range(0, 4 * scale)) - 2 * scale);
      w.center_z = 16'($signed($urandom_range(0, 4 * scale)) - 2 * scale);
      w.radius   = 16'($urandom_range(0, scale));
      w.voxel_i  = 5'($urandom_range(0, dim_now[0] - 1));
      w.voxel_j  = 5'($urandom_range(0, dim_now[1] - 1));
      w.voxel_k  = 5'($urandom_range(0, dim_now[2] - 1));
    end
    return w;
  endfunction

  task automatic random_items(int count);
    for (int n = 0; n < count; n++) begin
      send_word(random_word());
      maybe_pause();
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_gaps = 1'b0;
    scale = 256;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a 4x3x2 cubic cell of edge 4.0, set during clearing.
    load_cubic(1024, 6'd4, 6'd3, 6'd2);
    send_word(make_word(REQ_SET, 0, 0, 0, 256, 256, 0, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_ADD, 0, 0, 0, 600, 32767, 0, 0, 0));
    send_word(make_word(REQ_ADD, 0, 0, 0, 600, 32767, 0, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_SET, 32767, -32768, 32767, 65535, -32768, 31, 31, 31));
    send_word(make_word(REQ_ADD, -32768, 32767, -32768, 65535, -32768, 0, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 3, 2, 1));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 4, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 31, 31, 31));
    send_word(make_word(REQ_SET, 512, 384, 256, 0, 32767, 0, 0, 0));
    send_word(make_word(REQ_SET, -1, -1, -1, 1, 1, 0, 0, 0));
    send_word(make_word(REQ_READ, -1, -1, -1, 65535, -1, 3, 2, 1));
    send_word(make_word(REQ_NOP, -1, -1, -1, 65535, -1, 31, 31, 31));
    send_word(make_word(REQ_NOP, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 2, 1));
    random_items(10);

    // Extreme rows, and clamped grid fields: above the maximum and zero.
    drain();
    load_setting(48'h7FFF_8000_FFFF, 48'h8000_7FFF_0001, 48'hFFFF_0000_7FFF,
                 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF,
                 6'd63, 6'd0, 6'd2);
    scale = 32767;
    send_word(make_word(REQ_SET, 100, -100, 7, 65535, 4660, 0, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 31, 0, 1));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 31, 1, 1));
    random_items(8);

    // Shrunken grid: old voxels remain stored but out of reach.
    drain();
    load_cubic(512, 6'd1, 6'd1, 6'd1);
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 1, 0, 0));
    random_items(6);

    // Tall axes: one axis at the maximum count.
    drain();
    load_cubic(2048, 6'd2, 6'd32, 6'd1);
    random_items(8);

    // Random rows and small random grids; one phase without gaps.
    for (int p = 0; p < 5; p++) begin
      drain();
      if (p[0])
        load_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     6'($urandom_range(0, 4)), 6'($urandom_range(0, 4)),
                     6'($urandom_range(0, 4)));
      else
        load_cubic($urandom_range(64, 2048), 6'($urandom_range(1, 4)),
                   6'($urandom_range(1, 4)), 6'($urandom_range(1, 4)));
      if (p[0]) scale = 32767;
      no_gaps = (p == 2);
      random_items(8);
      // In one phase the sender waits for every result before going on.
      if (p == 1) drain();
      random_items(3);
    end
    no_gaps = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
